>>> src/npi_pkg.sv
// Shared constants, codes and handshake types of the normal probability integrator.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package npi_pkg;

    // Bounds are in hundredths of a point and are clipped to this limit.
    localparam int STEPS_PER_UNIT = 100;
    localparam int MAX_BOUND      = 200;
    localparam int BOUND_LIM      = MAX_BOUND * STEPS_PER_UNIT;

    localparam logic [23:0] LN2_Q24      = 24'd11629080;
    localparam logic [31:0] SCALE_Q16    = 32'd2614508129;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd12;
    localparam logic [16:0] PCT_MAX      = 17'd100000;
    localparam logic [14:0] MEAN_RESET   = 15'd10000;
    localparam logic [14:0] STD_RESET    = 15'd1500;

    // Configuration register indexes.
    localparam logic REG_MEAN = 1'b0;
    localparam logic REG_STD  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEV = 2'd1,
        STAT_REVERSED = 2'd2
    } status_t;

    // Request to the density unit; the top level holds d and s2 steady.
    typedef struct packed {
        logic        start;
        logic [15:0] d;
        logic [29:0] s2;
        logic [35:0] s2_tail;
    } smp_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] value;
    } smp_rsp_t;

endpackage

>>> src/npi_sample.sv
// Density sample unit: exp(-d^2 / (2 s^2)) in Q32 from one shared compare-subtract
// unit and one 32x32 multiplier. Depends on npi_pkg.
`timescale 1ns / 1ps

module npi_sample
(
    input  logic              clk,
    input  logic              rst_n,
    input  npi_pkg::smp_req_t req,
    output npi_pkg::smp_rsp_t rsp
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TAIL  = 7'b0000010,
        S_DIVX  = 7'b0000100,
        S_DIVK  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIVN  = 7'b0100000,
        S_SHIFT = 7'b1000000
    } smp_state_t;

    smp_state_t  state_reg, state_next;
    logic [31:0] d2_reg, d2_next;
    logic [57:0] rem_reg, rem_next;
    logic [57:0] dvs_reg, dvs_next;
    logic [28:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [5:0]  k_reg, k_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] term_reg, term_next;
    logic [31:0] p_reg, p_next;
    logic [32:0] sum_reg, sum_next;
    logic [3:0]  n_reg, n_next;
    logic [3:0]  nrem_reg, nrem_next;
    logic        done_reg, done_next;
    logic [32:0] val_reg, val_next;

    logic        ge;
    logic [57:0] rem_sub;
    logic [63:0] prod;
    logic [31:0] pw;
    logic [3:0]  rm;
    logic [4:0]  t;

    // Shared restoring-division step, used for both x and k.
    assign ge      = (rem_reg >= dvs_reg);
    assign rem_sub = ge ? (rem_reg - dvs_reg) : rem_reg;
    assign prod    = term_reg * r_reg;

    // Eight quotient bits a cycle of the division by the term index.
    always_comb
    begin
        rm = nrem_reg;
        pw = p_reg;
        t  = 5'd0;
        for (int j = 0; j < 8; j++)
        begin
            t  = {rm, pw[31]};
            pw = {pw[30:0], 1'b0};
            if (t >= {1'b0, n_reg})
            begin
                t     = t - {1'b0, n_reg};
                pw[0] = 1'b1;
            end
            rm = t[3:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        d2_next    = d2_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        term_next  = term_reg;
        p_next     = p_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        nrem_next  = nrem_reg;
        done_next  = 1'b0;
        val_next   = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    d2_next    = req.d * req.d;
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if ({4'b0, d2_reg} >= req.s2_tail)
                begin
                    val_next   = 33'd0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rem_next   = {3'b0, d2_reg, 23'b0};
                    dvs_next   = {req.s2, 28'b0};
                    q_next     = 29'd0;
                    cnt_next   = 5'd28;
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                rem_next = rem_sub;
                dvs_next = dvs_reg >> 1;
                q_next   = {q_reg[27:0], ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    // Quotient x is complete; split it by ln 2 next.
                    rem_next   = {29'b0, q_reg[27:0], ge};
                    dvs_next   = {34'b0, npi_pkg::LN2_Q24} << 5;
                    q_next     = 29'd0;
                    cnt_next   = 5'd5;
                    state_next = S_DIVK;
                end
            end
            S_DIVK:
            begin
                rem_next = rem_sub;
                dvs_next = dvs_reg >> 1;
                q_next   = {q_reg[27:0], ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    // The first Taylor term is r itself.
                    k_next     = {q_reg[4:0], ge};
                    r_next     = {rem_sub[23:0], 8'b0};
                    term_next  = {rem_sub[23:0], 8'b0};
                    sum_next   = {1'b1, 32'b0} - {1'b0, rem_sub[23:0], 8'b0};
                    n_next     = 4'd2;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                p_next     = prod[63:32];
                nrem_next  = 4'd0;
                cnt_next   = 5'd3;
                state_next = S_DIVN;
            end
            S_DIVN:
            begin
                p_next    = pw;
                nrem_next = rm;
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    term_next = pw;
                    if (n_reg[0])
                    begin
                        sum_next = sum_reg - {1'b0, pw};
                    end
                    else
                    begin
                        sum_next = sum_reg + {1'b0, pw};
                    end
                    if (n_reg == npi_pkg::TAYLOR_TERMS)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        n_next     = n_reg + 4'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_SHIFT:
            begin
                val_next   = sum_reg >> k_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d2_reg   <= d2_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        term_reg <= term_next;
        p_reg    <= p_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        nrem_reg <= nrem_next;
        val_reg  <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule

>>> src/normal_probability_integrator.sv
// Top level of the normal probability integrator: configuration, bound handling,
// accumulation, final scaling. Depends on npi_pkg and npi_sample.
`timescale 1ns / 1ps

// A query is taken when start is high and busy is low; its word appears on
// percent_milli and status while done is high for exactly one cycle, and the
// receiver cannot stall it. A rejected query (zero deviation or reversed
// bounds) answers in the next cycle. Otherwise the density is sampled once per
// hundredth inside the range, by the sample unit's 29-step quotient and 12-term
// series, which are skipped for points beyond the tail bound; squaring and the
// tail bound come first, and a final 48-step division and scaling follow.
// Configuration writes must be done while busy is low.
module normal_probability_integrator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [14:0] wr_data,
    input  logic        start,
    input  logic        action,
    input  logic [14:0] iq_first,
    input  logic [14:0] iq_second,
    output logic        busy,
    output logic        done,
    output logic [16:0] percent_milli,
    output logic [1:0]  status
);

    typedef enum logic [7:0] {
        T_IDLE = 8'b00000001,
        T_SQR  = 8'b00000010,
        T_TAIL = 8'b00000100,
        T_RUN  = 8'b00001000,
        T_WAIT = 8'b00010000,
        T_DIVA = 8'b00100000,
        T_MUL  = 8'b01000000,
        T_OUT  = 8'b10000000
    } top_state_t;

    top_state_t       state_reg, state_next;
    logic [14:0]      mean_reg, std_reg;
    logic [15:0]      z_reg, z_next;
    logic [15:0]      end_reg, end_next;
    logic [47:0]      acc_reg, acc_next;
    logic [29:0]      s2_reg, s2_next;
    logic [35:0]      tail_reg, tail_next;
    logic [61:0]      arem_reg, arem_next;
    logic [61:0]      advs_reg, advs_next;
    logic [47:0]      qa_reg, qa_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [31:0]      qlo_reg, qlo_next;
    logic [63:0]      prod_reg, prod_next;
    logic [16:0]      pct_reg, pct_next;
    npi_pkg::status_t status_reg, status_next;
    logic             done_reg, done_next;

    logic [15:0]       lo, hi, z_d;
    logic              age;
    logic [61:0]       arem_sub;
    logic [47:0]       qa_new;
    logic [63:0]       rnd;
    npi_pkg::smp_req_t req;
    npi_pkg::smp_rsp_t rsp;

    assign lo = (32'(iq_first) > npi_pkg::BOUND_LIM) ? 16'(npi_pkg::BOUND_LIM)
                                                      : {1'b0, iq_first};
    assign hi = (32'(iq_second) > npi_pkg::BOUND_LIM) ? 16'(npi_pkg::BOUND_LIM)
                                                       : {1'b0, iq_second};
    assign z_d = (z_reg > {1'b0, mean_reg}) ? (z_reg - {1'b0, mean_reg})
                                             : ({1'b0, mean_reg} - z_reg);

    assign age      = (arem_reg >= advs_reg);
    assign arem_sub = age ? (arem_reg - advs_reg) : arem_reg;
    assign qa_new   = {qa_reg[46:0], age};
    assign rnd      = prod_reg + {24'b0, 1'b1, 39'b0};

    assign req.start   = state_reg[0] ? 1'b0 : ((state_reg == T_RUN) && (z_reg < end_reg));
    assign req.d       = z_d;
    assign req.s2      = s2_reg;
    assign req.s2_tail = tail_reg;

    npi_sample u_sample
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        z_next      = z_reg;
        end_next    = end_reg;
        acc_next    = acc_reg;
        s2_next     = s2_reg;
        tail_next   = tail_reg;
        arem_next   = arem_reg;
        advs_next   = advs_reg;
        qa_next     = qa_reg;
        cnt_next    = cnt_reg;
        qlo_next    = qlo_reg;
        prod_next   = prod_reg;
        pct_next    = pct_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    if (std_reg == 15'd0)
                    begin
                        pct_next    = 17'd0;
                        status_next = npi_pkg::STAT_ZERO_DEV;
                        done_next   = 1'b1;
                    end
                    else if (action && (hi < lo))
                    begin
                        pct_next    = 17'd0;
                        status_next = npi_pkg::STAT_REVERSED;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // Mode 0 runs from zero through the first bound.
                        z_next     = action ? lo : 16'd0;
                        end_next   = action ? hi : (lo + 16'd1);
                        acc_next   = 48'd0;
                        state_next = T_SQR;
                    end
                end
            end
            T_SQR:
            begin
                s2_next    = std_reg * std_reg;
                state_next = T_TAIL;
            end
            T_TAIL:
            begin
                // 46 * s^2 as a sum of shifts.
                tail_next  = {1'b0, s2_reg, 5'b0} + {3'b0, s2_reg, 3'b0}
                           + {4'b0, s2_reg, 2'b0} + {5'b0, s2_reg, 1'b0};
                state_next = T_RUN;
            end
            T_RUN:
            begin
                if (z_reg < end_reg)
                begin
                    state_next = T_WAIT;
                end
                else
                begin
                    arem_next  = {14'b0, acc_reg};
                    advs_next  = {std_reg, 47'b0};
                    qa_next    = 48'd0;
                    cnt_next   = 6'd47;
                    state_next = T_DIVA;
                end
            end
            T_WAIT:
            begin
                if (rsp.done)
                begin
                    acc_next   = acc_reg + {15'b0, rsp.value};
                    z_next     = z_reg + 16'd1;
                    state_next = T_RUN;
                end
            end
            T_DIVA:
            begin
                arem_next = arem_sub;
                advs_next = advs_reg >> 1;
                qa_next   = qa_new;
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    status_next = npi_pkg::STAT_OK;
                    if (qa_new[47:40] != 8'd0)
                    begin
                        // A share at or above 2^32 in Q24 is far past full scale.
                        pct_next   = npi_pkg::PCT_MAX;
                        done_next  = 1'b1;
                        state_next = T_IDLE;
                    end
                    else
                    begin
                        qlo_next   = qa_new[39:8];
                        state_next = T_MUL;
                    end
                end
            end
            T_MUL:
            begin
                prod_next  = qlo_reg * npi_pkg::SCALE_Q16;
                state_next = T_OUT;
            end
            T_OUT:
            begin
                pct_next   = (rnd[63:40] > {7'b0, npi_pkg::PCT_MAX}) ? npi_pkg::PCT_MAX
                                                                     : rnd[56:40];
                done_next  = 1'b1;
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
            mean_reg  <= npi_pkg::MEAN_RESET;
            std_reg   <= npi_pkg::STD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    npi_pkg::REG_MEAN: mean_reg <= wr_data;
                    npi_pkg::REG_STD:  std_reg  <= wr_data;
                    default:           mean_reg <= mean_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg      <= z_next;
        end_reg    <= end_next;
        acc_reg    <= acc_next;
        s2_reg     <= s2_next;
        tail_reg   <= tail_next;
        arem_reg   <= arem_next;
        advs_reg   <= advs_next;
        qa_reg     <= qa_next;
        cnt_reg    <= cnt_next;
        qlo_reg    <= qlo_next;
        prod_reg   <= prod_next;
        pct_reg    <= pct_next;
        status_reg <= status_next;
    end

    assign busy          = !state_reg[0];
    assign done          = done_reg;
    assign percent_milli = pct_reg;
    assign status        = status_reg;

endmodule

>>> tb/sv/normal_probability_integrator_tb.sv
// Testbench for the normal probability integrator: directed and random queries,
// checked against a fixed-point predictor of the density sum. Depends on npi_pkg
// and normal_probability_integrator.
`timescale 1ns / 1ps

module normal_probability_integrator_tb;

    localparam int WATCHDOG_LIMIT = 2500000;
    localparam longint unsigned TAIL_FACTOR = 46;
    localparam int SERIES_TERMS = 12;

    typedef struct {
        logic [16:0]      pct;
        npi_pkg::status_t st;
    } share_t;

    // Holds the shares still owed by the block, oldest first.
    class share_board;
        share_t owed[$];

        function void note(share_t s);
            owed.push_back(s);
        endfunction

        // 0: match, 1: nothing owed, 2: mismatch (exp holds the expectation).
        function int check(logic [16:0] pct, logic [1:0] st, output share_t exp);
            if (owed.size() == 0)
                return 1;
            exp = owed.pop_front();
            if (pct !== exp.pct || st !== exp.st)
                return 2;
            return 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic        wr_index;
    logic [14:0] wr_data;
    logic        start;
    logic        action;
    logic [14:0] iq_first;
    logic [14:0] iq_second;
    logic        busy;
    logic        done;
    logic [16:0] percent_milli;
    logic [1:0]  status;

    logic [14:0] cfg_mean;
    logic [14:0] cfg_std;
    int          errors = 0;
    int          idle_pct;
    int          quiet_cycles = 0;
    share_board  board;

    normal_probability_integrator dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .start(start),
        .action(action),
        .iq_first(iq_first),
        .iq_second(iq_second),
        .busy(busy),
        .done(done),
        .percent_milli(percent_milli),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint unsigned clip_bound(logic [14:0] v);
        if (v > npi_pkg::BOUND_LIM)
            return npi_pkg::BOUND_LIM;
        return v;
    endfunction

    // Gaussian density at one point, Q32 before scaling by the deviation.
    function automatic longint unsigned density(longint unsigned z, longint unsigned m,
                                                longint unsigned s);
        longint unsigned d, d2, s2, x, k, r, sum, term;
        d  = (z > m) ? z - m : m - z;
        d2 = d * d;
        s2 = s * s;
        if (d2 >= TAIL_FACTOR * s2)
            return 0;
        x = (d2 << 23) / s2;
        k = x / npi_pkg::LN2_Q24;
        r = (x - k * npi_pkg::LN2_Q24) << 8;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = ((term * r) >> 32) / n;
            if (n % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        if (k > 63)
            return 0;
        return sum >> k;
    endfunction

    function automatic share_t predict_share(logic act, logic [14:0] a, logic [14:0] b);
        share_t res;
        longint unsigned lo, hi, z, stop, acc, q, pct;
        lo  = clip_bound(a);
        hi  = clip_bound(b);
        acc = 0;
        res.pct = '0;
        res.st  = npi_pkg::STAT_OK;
        if (cfg_std == 0)
        begin
            res.st = npi_pkg::STAT_ZERO_DEV;
            return res;
        end
        if (act && hi < lo)
        begin
            res.st = npi_pkg::STAT_REVERSED;
            return res;
        end
        z    = act ? lo : 0;
        stop = act ? hi : lo + 1;
        for (; z < stop; z++)
            acc += density(z, cfg_mean, cfg_std);
        q = (acc / cfg_std) >> 8;
        if (q > (64'd1 << 32))
            q = 64'd1 << 32;
        pct = (q * npi_pkg::SCALE_Q16 + (64'd1 << 39)) >> 40;
        if (pct > npi_pkg::PCT_MAX)
            pct = npi_pkg::PCT_MAX;
        res.pct = pct[16:0];
        return res;
    endfunction

    // Results are checked at the edge that ends their cycle.
    always @(posedge clk)
    begin
        share_t exp;
        int     rc;
        if (rst_n && done)
        begin
            rc = board.check(percent_milli, status, exp);
            if (rc == 1)
                report_mismatch($sformatf("unexpected word pct=%0d status=%0d",
                                          percent_milli, status));
            else if (rc == 2)
                report_mismatch($sformatf("got pct=%0d status=%0d, want pct=%0d status=%0d",
                                          percent_milli, status, exp.pct, exp.st));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_query(input logic act, input logic [14:0] a, input logic [14:0] b);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start     = 1'b1;
        action    = act;
        iq_first  = a;
        iq_second = b;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        board.note(predict_share(act, a, b));
    endtask

    // Lets the block drain before registers change.
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (board.pending() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [14:0] val);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = val;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == npi_pkg::REG_MEAN)
            cfg_mean = val;
        else
            cfg_std = val;
    endtask

    task automatic random_phase(input int count);
        logic [14:0] a;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                send_query(1'b0, 15'($urandom_range(150)), 15'($urandom));
            end
            else if (pick < 30)
            begin
                a = 15'($urandom_range(20000, 1));
                send_query(1'b1, a, 15'(a - $urandom_range(a < 30 ? a : 30, 1)));
            end
            else if (pick < 38)
            begin
                a = 15'($urandom_range(32767, 20000));
                send_query(1'b1, a, 15'($urandom_range(32767, 20000)));
            end
            else
            begin
                a = 15'($urandom_range(19960));
                send_query(1'b1, a, 15'(a + $urandom_range(40)));
            end
        end
    endtask

    initial
    begin
        board     = new();
        idle_pct  = 0;
        rst_n     = 1'b0;
        wr_en     = 1'b0;
        wr_index  = npi_pkg::REG_MEAN;
        wr_data   = '0;
        start     = 1'b0;
        action    = 1'b0;
        iq_first  = '0;
        iq_second = '0;
        cfg_mean  = npi_pkg::MEAN_RESET;
        cfg_std   = npi_pkg::STD_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings.
        send_query(1'b0, 15'd0, 15'h7fff);
        send_query(1'b1, 15'd5000, 15'd5000);
        send_query(1'b1, 15'd5001, 15'd5000);
        send_query(1'b1, 15'd9980, 15'd10020);
        wait_drained();

        // Zero deviation is rejected in both modes.
        write_reg(npi_pkg::REG_STD, 15'd0);
        send_query(1'b0, 15'd100, 15'd0);
        send_query(1'b1, 15'd10, 15'd20);
        wait_drained();

        // Narrowest deviation with the mean at its top: every point is in the tail.
        write_reg(npi_pkg::REG_STD, 15'd1);
        write_reg(npi_pkg::REG_MEAN, 15'd25500);
        send_query(1'b0, 15'h7fff, 15'h7fff);
        send_query(1'b1, 15'd0, 15'h7fff);
        send_query(1'b1, 15'd25000, 15'd21000);
        wait_drained();

        write_reg(npi_pkg::REG_MEAN, 15'd0);
        write_reg(npi_pkg::REG_STD, 15'd25500);
        send_query(1'b1, 15'd0, 15'd40);
        send_query(1'b0, 15'd20, 15'd0);
        wait_drained();

        write_reg(npi_pkg::REG_MEAN, 15'd16383);
        write_reg(npi_pkg::REG_STD, 15'd16383);
        send_query(1'b1, 15'd16370, 15'd16400);
        wait_drained();

        write_reg(npi_pkg::REG_MEAN, 15'd10000);
        write_reg(npi_pkg::REG_STD, 15'd100);
        send_query(1'b1, 15'd9000, 15'd11000);
        send_query(1'b0, 15'd9999, 15'd1);
        wait_drained();

        // Random part in three phases of sender idling.
        write_reg(npi_pkg::REG_MEAN, 15'($urandom_range(25500)));
        write_reg(npi_pkg::REG_STD, 15'($urandom_range(25500, 1000)));
        idle_pct = 13;
        random_phase(34);
        wait_drained();

        write_reg(npi_pkg::REG_MEAN, 15'($urandom_range(25500)));
        write_reg(npi_pkg::REG_STD, 15'($urandom_range(300, 1)));
        idle_pct = 68;
        random_phase(33);
        wait_drained();

        write_reg(npi_pkg::REG_MEAN, 15'($urandom_range(25500)));
        write_reg(npi_pkg::REG_STD, 15'($urandom_range(25500, 1)));
        idle_pct = 0;
        random_phase(33);
        wait_drained();

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
